@@ rtl/assert_macros.svh @@
// concurrent assertion helpers, clocked on clock and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ rtl/b64d_pkg.sv @@
package b64d_pkg;

   localparam int SYM_W = 8;
   localparam int SEXTET_W = 6;
   localparam int BYTE_W = 8;
   localparam int GROUP_N = 3;

   localparam logic [SYM_W-1:0] PAD_SYMBOL = 8'h3d;

   typedef enum logic [1:0] {
      CAUSE_END     = 2'd0,
      CAUSE_PAD     = 2'd1,
      CAUSE_INVALID = 2'd2
   } cause_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_present;
      logic              final_result;
      logic [1:0]        stop_cause;
   } rsp_payload_type;

   // up to three words produced by one accepted character
   typedef struct packed {
      logic [GROUP_N-1:0][BYTE_W-1:0] bytes;
      logic [1:0]                     last_idx;
      logic                           present;
      logic                           fin;
      cause_type                      cause;
   } group_type;

   // bit 6 set: not in the alphabet
   function automatic logic [SEXTET_W:0] map_symbol(logic [SYM_W-1:0] c);
      logic [SEXTET_W:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2b) begin
         v = 7'd62;
      end else if (c == 8'h2f) begin
         v = 7'd63;
      end
      return v;
   endfunction

   function automatic logic is_space(logic [SYM_W-1:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
   endfunction

   function automatic logic [BYTE_W-1:0] join0(logic [5:0] s0, logic [5:0] s1);
      return {s0, s1[5:4]};
   endfunction

   function automatic logic [BYTE_W-1:0] join1(logic [5:0] s1, logic [5:0] s2);
      return {s1[3:0], s2[5:2]};
   endfunction

   function automatic logic [BYTE_W-1:0] join2(logic [5:0] s2, logic [5:0] s3);
      return {s2[1:0], s3};
   endfunction

endpackage

@@ rtl/b64d_stream_if.sv @@
interface b64d_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/b64d_input_stage.sv @@
module b64d_input_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  b64d_pkg::req_payload_type req_item,
   output logic                      req_ready,
   input  logic                      take,
   output logic                      item_valid,
   output b64d_pkg::req_payload_type item
);

   logic                      valid_ff;
   b64d_pkg::req_payload_type item_ff;

   assign req_ready = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

@@ rtl/b64d_decode.sv @@
module b64d_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  b64d_pkg::req_payload_type item,
   input  logic                      grp_ready,
   output logic                      take,
   output logic                      grp_push,
   output b64d_pkg::group_type       grp_data
);

   logic [b64d_pkg::GROUP_N-1:0][b64d_pkg::SEXTET_W-1:0] sextet_ff, sextet_in;
   logic [1:0]          held_ff, held_in;
   logic                halted_ff, halted_in;
   b64d_pkg::cause_type cause_ff, cause_in;

   logic [b64d_pkg::SEXTET_W:0] mapped;
   logic                        emits;

   always_comb begin
      mapped = b64d_pkg::map_symbol(item.symbol);
      sextet_in = sextet_ff;
      held_in = held_ff;
      halted_in = halted_ff;
      cause_in = cause_ff;
      emits = 1'b0;
      grp_data = '0;
      grp_data.cause = b64d_pkg::CAUSE_END;

      if (item.end_of_text) begin
         emits = 1'b1;
         grp_data.fin = 1'b1;
         grp_data.cause = halted_ff ? cause_ff : b64d_pkg::CAUSE_END;
         unique case (held_ff)
            2'd2: begin
               grp_data.bytes[0] = b64d_pkg::join0(sextet_ff[0], sextet_ff[1]);
               grp_data.present = 1'b1;
            end
            2'd3: begin
               grp_data.bytes[0] = b64d_pkg::join0(sextet_ff[0], sextet_ff[1]);
               grp_data.bytes[1] = b64d_pkg::join1(sextet_ff[1], sextet_ff[2]);
               grp_data.last_idx = 2'd1;
               grp_data.present = 1'b1;
            end
            default: begin
               grp_data.present = 1'b0;
            end
         endcase
         held_in = 2'd0;
         halted_in = 1'b0;
         cause_in = b64d_pkg::CAUSE_END;
      end else if (!halted_ff && !b64d_pkg::is_space(item.symbol)) begin
         priority if (item.symbol == b64d_pkg::PAD_SYMBOL) begin
            halted_in = 1'b1;
            cause_in = b64d_pkg::CAUSE_PAD;
         end else if (mapped[b64d_pkg::SEXTET_W]) begin
            halted_in = 1'b1;
            cause_in = b64d_pkg::CAUSE_INVALID;
         end else if (held_ff != 2'd3) begin
            sextet_in[held_ff] = mapped[b64d_pkg::SEXTET_W-1:0];
            held_in = held_ff + 2'd1;
         end else begin
            // fourth sextet completes the group
            emits = 1'b1;
            grp_data.bytes[0] = b64d_pkg::join0(sextet_ff[0], sextet_ff[1]);
            grp_data.bytes[1] = b64d_pkg::join1(sextet_ff[1], sextet_ff[2]);
            grp_data.bytes[2] = b64d_pkg::join2(sextet_ff[2],
                                                mapped[b64d_pkg::SEXTET_W-1:0]);
            grp_data.last_idx = 2'd2;
            grp_data.present = 1'b1;
            held_in = 2'd0;
         end
      end

      take = item_valid && (grp_ready || !emits);
      grp_push = take && emits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         halted_ff <= 1'b0;
         cause_ff <= b64d_pkg::CAUSE_END;
      end else if (take) begin
         held_ff <= held_in;
         halted_ff <= halted_in;
         cause_ff <= cause_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sextet_ff <= sextet_in;
      end
   end

endmodule

@@ rtl/b64d_serializer.sv @@
module b64d_serializer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      grp_push,
   input  b64d_pkg::group_type       grp_data,
   output logic                      grp_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output b64d_pkg::rsp_payload_type rsp_item
);

   b64d_pkg::group_type grp_ff;
   logic                grp_valid_ff;
   logic [1:0]          idx_ff;
   logic                is_last;
   logic                fire;

   assign is_last = idx_ff == grp_ff.last_idx;
   assign fire = grp_valid_ff && rsp_ready;
   assign grp_ready = !grp_valid_ff || (fire && is_last);
   assign rsp_valid = grp_valid_ff;

   always_comb begin
      rsp_item.byte_present = grp_ff.present;
      rsp_item.data_byte = grp_ff.present ? grp_ff.bytes[idx_ff] : '0;
      rsp_item.final_result = grp_ff.fin && is_last;
      rsp_item.stop_cause = (grp_ff.fin && is_last) ? grp_ff.cause
                                                    : b64d_pkg::CAUSE_END;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else if (grp_push) begin
         grp_valid_ff <= 1'b1;
         idx_ff <= 2'd0;
      end else if (fire) begin
         if (is_last) begin
            grp_valid_ff <= 1'b0;
            idx_ff <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_push) begin
         grp_ff <= grp_data;
      end
   end

endmodule

@@ rtl/base64_stream_decoder_core.sv @@
// base64 decoder, one character word in per req handshake, one byte word out per rsp
// handshake. req carries symbol and end_of_text; rsp carries data_byte, byte_present,
// final_result and stop_cause.
// whitespace is dropped, the first pad or non-alphabet character halts decoding until
// end_of_text; every fourth alphabet character gives three bytes, and end_of_text
// flushes a partial group and closes with a final word carrying the stop cause.
// a character waits in the input register; one that yields words is decoded
// combinationally into the group register, whose first byte then drives rsp.
// throughput: one character per cycle while the group register is free or the
// character yields no word. a full group or an end marker holds the group register
// until each word it yields (three, two or one) has left the single output register;
// characters that yield nothing keep flowing meanwhile. when rsp stalls, the
// group register holds; req backs up only when the next character itself needs it.
// reset (synchronous) empties both registers and clears the collected group and
// halt state; no clearing pass is needed.
`include "assert_macros.svh"

module base64_stream_decoder_core (
   input logic           clock,
   input logic           reset,
   b64d_stream_if.sink   req,
   b64d_stream_if.source rsp
);

   logic                      item_valid;
   b64d_pkg::req_payload_type item;
   logic                      take;
   logic                      grp_push;
   logic                      grp_ready;
   b64d_pkg::group_type       grp_data;
   b64d_pkg::rsp_payload_type rsp_item;

   b64d_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_item   (req.payload),
      .req_ready  (req.ready),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   b64d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .grp_ready  (grp_ready),
      .take       (take),
      .grp_push   (grp_push),
      .grp_data   (grp_data)
   );

   b64d_serializer u_serial (
      .clock     (clock),
      .reset     (reset),
      .grp_push  (grp_push),
      .grp_data  (grp_data),
      .grp_ready (grp_ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp.payload = rsp_item;

   `ASSERT_NEVER(a_no_overwrite, grp_push && !grp_ready, "group pushed over pending words")
   `ASSERT_PROP(a_take_needs_item, take |-> item_valid, "character decoded without one held")
   `ASSERT_PROP(a_empty_only_final, rsp.valid && !rsp_item.byte_present |-> rsp_item.final_result, "word without byte that is not final")
   `ASSERT_PROP(a_cause_on_final, rsp.valid && !rsp_item.final_result |-> rsp_item.stop_cause == b64d_pkg::CAUSE_END, "stop cause on a non-final word")

endmodule
